// ----- hdl/etc1_pkg.sv -----
// Package for the ETC1 block decoder: payload and queue entry types,
// register indexes, the modifier table and the reciprocal used for premultiply.
// Depends on nothing; every other file of the block but etc1_stream_if uses it.
`timescale 1ns / 1ps
`default_nettype none
package etc1_pkg;

   localparam int Q_DEPTH = 2;

   typedef enum logic [0:0] {
      CSR_HAS_ALPHA   = 1'b0,
      CSR_PREMULTIPLY = 1'b1
   } csr_index_type;

   // floor(x / 15) equals (x * 4370) >> 16 for every x up to 255 * 15.
   localparam logic [12:0] RECIP_15 = 13'd4370;
   localparam int RECIP_SHIFT = 16;

   typedef struct packed {
      logic [63:0] color_word;
      logic [63:0] alpha_word;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [1:0] pixel_x;
      logic [1:0] pixel_y;
      logic       last_pixel;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      rgb_type     base0;
      rgb_type     base1;
      logic [2:0]  tbl0;
      logic [2:0]  tbl1;
      logic        flip;
      logic [15:0] lsbs;
      logic [15:0] msbs;
      logic [63:0] alpha_word;
   } block_type;

   typedef struct packed {
      logic      head_valid;
      block_type head;
   } queue_head_type;

   function automatic logic [7:0] mod_mag(input logic [2:0] tbl, input logic sel);
      logic [7:0] lo;
      logic [7:0] hi;
      unique case (tbl)
         3'd0: begin lo = 8'd2;  hi = 8'd8;   end
         3'd1: begin lo = 8'd5;  hi = 8'd17;  end
         3'd2: begin lo = 8'd9;  hi = 8'd29;  end
         3'd3: begin lo = 8'd13; hi = 8'd42;  end
         3'd4: begin lo = 8'd18; hi = 8'd60;  end
         3'd5: begin lo = 8'd24; hi = 8'd80;  end
         3'd6: begin lo = 8'd33; hi = 8'd106; end
         default: begin lo = 8'd47; hi = 8'd183; end
      endcase
      return sel ? hi : lo;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/etc1_stream_if.sv -----
// Valid/ready stream interface carrying one payload per beat.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface etc1_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/etc1_front.sv -----
// Front end: accepts a block beat and works out the two sub-block base colours,
// table indices and flip bit. Depends on etc1_pkg and etc1_stream_if.
`timescale 1ns / 1ps
`default_nettype none
module etc1_front (
   etc1_stream_if.sink           req_bus,
   input  wire logic             full,
   output logic                  push,
   output etc1_pkg::block_type   push_data
);

   logic [63:0] cw;
   logic        diff;

   function automatic logic [7:0] base_first(input logic [7:0] f, input logic diff_mode);
      return diff_mode ? {f[7:3], f[7:5]} : {f[7:4], f[7:4]};
   endfunction

   function automatic logic [7:0] base_second(input logic [7:0] f, input logic diff_mode);
      logic [4:0] v;
      v = f[7:3] + {{2{f[2]}}, f[2:0]};
      return diff_mode ? {v, v[4:2]} : {f[3:0], f[3:0]};
   endfunction

   assign cw            = req_bus.payload.color_word;
   assign diff          = cw[33];
   assign req_bus.ready = !full;
   assign push          = req_bus.valid && !full;

   always_comb begin
      push_data.base0.red    = base_first(cw[63:56], diff);
      push_data.base0.green  = base_first(cw[55:48], diff);
      push_data.base0.blue   = base_first(cw[47:40], diff);
      push_data.base1.red    = base_second(cw[63:56], diff);
      push_data.base1.green  = base_second(cw[55:48], diff);
      push_data.base1.blue   = base_second(cw[47:40], diff);
      push_data.tbl0         = cw[39:37];
      push_data.tbl1         = cw[36:34];
      push_data.flip         = cw[32];
      push_data.lsbs         = cw[15:0];
      push_data.msbs         = cw[31:16];
      push_data.alpha_word   = req_bus.payload.alpha_word;
   end

endmodule
`default_nettype wire

// ----- hdl/etc1_queue.sv -----
// Short register queue of decoded block headers between front and back end.
// Depends on etc1_pkg.
`timescale 1ns / 1ps
`default_nettype none
module etc1_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire etc1_pkg::block_type   push_data,
   output logic                       full,
   input  wire logic                  pop,
   output etc1_pkg::queue_head_type   head
);

   localparam int PW = (etc1_pkg::Q_DEPTH > 1) ? $clog2(etc1_pkg::Q_DEPTH) : 1;
   localparam int CW = $clog2(etc1_pkg::Q_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(etc1_pkg::Q_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(etc1_pkg::Q_DEPTH);

   etc1_pkg::block_type entry_ff [etc1_pkg::Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full            = (count_ff == DEPTH_C);
   assign head.head_valid = (count_ff != '0);
   assign head.head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/etc1_back.sv -----
// Back end: walks the sixteen pixels of the head block in column-major order
// through a three-stage pipeline (pixel colour, alpha product, divide by 15).
// Depends on etc1_pkg and etc1_stream_if.
`timescale 1ns / 1ps
`default_nettype none
module etc1_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  has_alpha,
   input  wire logic                  premultiply,
   input  wire etc1_pkg::queue_head_type head,
   output logic                       pop,
   etc1_stream_if.source              rsp_bus
);

   etc1_pkg::block_type blk;
   logic       adv;
   logic       take;
   logic [3:0] k_ff, k_in;

   logic       second;
   logic [2:0] tbl;
   logic [7:0] mag;
   logic       neg;
   logic [3:0] nib;
   etc1_pkg::rgb_type base;
   etc1_pkg::rgb_type pix;

   logic       s1_valid_ff;
   etc1_pkg::rgb_type s1_rgb_ff;
   logic [3:0] s1_nib_ff, s1_mul_ff;
   logic [3:0] s1_k_ff;

   logic        s2_valid_ff;
   logic [11:0] s2_r_ff, s2_g_ff, s2_b_ff;
   logic [3:0]  s2_nib_ff;
   logic [3:0]  s2_k_ff;

   logic        s3_valid_ff;
   etc1_pkg::rsp_payload_type s3_ff;

   function automatic logic [7:0] clamp_add(input logic [7:0] b, input logic [7:0] m,
                                            input logic n);
      logic [8:0] sum;
      sum = {1'b0, b} + {1'b0, m};
      if (n) begin
         return (b >= m) ? b - m : 8'd0;
      end
      return sum[8] ? 8'hFF : sum[7:0];
   endfunction

   function automatic logic [7:0] div15(input logic [11:0] x);
      logic [24:0] p;
      p = {13'd0, x} * {12'd0, etc1_pkg::RECIP_15};
      return p[etc1_pkg::RECIP_SHIFT +: 8];
   endfunction

   assign blk  = head.head;
   assign adv  = !s3_valid_ff || rsp_bus.ready;
   assign take = adv && head.head_valid;
   assign pop  = take && (k_ff == 4'd15);
   assign k_in = take ? k_ff + 4'd1 : k_ff;

   always_comb begin
      second  = blk.flip ? k_ff[1] : k_ff[3];
      tbl     = second ? blk.tbl1 : blk.tbl0;
      mag     = etc1_pkg::mod_mag(tbl, blk.lsbs[k_ff]);
      neg     = blk.msbs[k_ff];
      base    = second ? blk.base1 : blk.base0;
      pix.red   = clamp_add(base.red, mag, neg);
      pix.green = clamp_add(base.green, mag, neg);
      pix.blue  = clamp_add(base.blue, mag, neg);
      nib     = has_alpha ? blk.alpha_word[{k_ff, 2'b00} +: 4] : 4'hF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff        <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         k_ff <= k_in;
         if (adv) begin
            s1_valid_ff <= head.head_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_rgb_ff <= pix;
         s1_nib_ff <= nib;
         s1_mul_ff <= premultiply ? nib : 4'hF;
         s1_k_ff   <= k_ff;

         s2_r_ff   <= {4'd0, s1_rgb_ff.red} * {8'd0, s1_mul_ff};
         s2_g_ff   <= {4'd0, s1_rgb_ff.green} * {8'd0, s1_mul_ff};
         s2_b_ff   <= {4'd0, s1_rgb_ff.blue} * {8'd0, s1_mul_ff};
         s2_nib_ff <= s1_nib_ff;
         s2_k_ff   <= s1_k_ff;

         s3_ff.red        <= div15(s2_r_ff);
         s3_ff.green      <= div15(s2_g_ff);
         s3_ff.blue       <= div15(s2_b_ff);
         s3_ff.alpha      <= {s2_nib_ff, s2_nib_ff};
         s3_ff.pixel_x    <= s2_k_ff[3:2];
         s3_ff.pixel_y    <= s2_k_ff[1:0];
         s3_ff.last_pixel <= (s2_k_ff == 4'd15);
      end
   end

   assign rsp_bus.valid   = s3_valid_ff;
   assign rsp_bus.payload = s3_ff;

endmodule
`default_nettype wire

// ----- hdl/etc1_block_decoder.sv -----
// Top level of the ETC1 block decoder: configuration registers, front end,
// header queue and pixel back end. Depends on etc1_pkg, etc1_stream_if,
// etc1_front, etc1_queue and etc1_back.
//
//   Channel   Direction  Per beat
//   req_bus   in         one block: color_word, alpha_word
//   rsp_bus   out        one pixel: red, green, blue, alpha, pixel_x, pixel_y, last_pixel
//   csr_*     in         one register write: csr_we, csr_index, csr_wdata
//
// Each block yields sixteen pixels, one per cycle unless rsp_bus stalls, set by
// the back-end pixel counter; the front takes the next block while the queue
// has room. A block beat is registered in the queue and then in each back-end stage.
// Reset is synchronous and clears both registers, the queue and all valids.
// A stall on rsp_bus holds the whole back-end pipeline; blocks keep entering
// until the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module etc1_block_decoder (
   input  wire logic    clock,
   input  wire logic    reset,
   etc1_stream_if.sink  req_bus,
   etc1_stream_if.source rsp_bus,
   input  wire logic    csr_we,
   input  wire logic    csr_index,
   input  wire logic    csr_wdata
);

   logic has_alpha_ff;
   logic premultiply_ff;
   logic push;
   logic full;
   logic pop;
   etc1_pkg::block_type      push_data;
   etc1_pkg::queue_head_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_alpha_ff   <= 1'b0;
         premultiply_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (etc1_pkg::csr_index_type'(csr_index))
            etc1_pkg::CSR_HAS_ALPHA:   has_alpha_ff   <= csr_wdata;
            etc1_pkg::CSR_PREMULTIPLY: premultiply_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   etc1_front u_front (
      .req_bus   (req_bus),
      .full      (full),
      .push      (push),
      .push_data (push_data)
   );

   etc1_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head)
   );

   etc1_back u_back (
      .clock       (clock),
      .reset       (reset),
      .has_alpha   (has_alpha_ff),
      .premultiply (premultiply_ff),
      .head        (head),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule
`default_nettype wire

// ----- hdl/etc1_checker.sv -----
// Port-level checks for the ETC1 block decoder and the bind that attaches them.
// Depends on etc1_pkg and etc1_block_decoder.
`timescale 1ns / 1ps
`default_nettype none
module etc1_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire etc1_pkg::rsp_payload_type  rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled response beat changed.");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_pixel |->
         rsp_payload.pixel_x == 2'd3 && rsp_payload.pixel_y == 2'd3)
      else $error("Last pixel flagged away from the final corner.");

   a_alpha_replicated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.alpha[7:4] == rsp_payload.alpha[3:0])
      else $error("Alpha is not a replicated nibble.");

   a_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("Response beat offered straight after reset.");

endmodule

bind etc1_block_decoder etc1_checker u_etc1_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);
`default_nettype wire

// ----- tb/etc1_block_decoder_checker.sv -----
// Checker for the ETC1 block decoder: follows the register writes, predicts
// sixteen pixels for every block beat and compares them with the pixel beats.
// Depends on etc1_pkg for the payload types and register indexes.
`timescale 1ns / 1ps
module etc1_block_decoder_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  etc1_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  etc1_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic                      csr_wdata,
   output int                        failures,
   output int                        pending_pixels
);

   localparam int PRINT_CAP = 40;

   // Modifier magnitudes per table, for index lsb 0 and index lsb 1.
   localparam logic [7:0][7:0] MOD_NEAR = {8'd47, 8'd33, 8'd24, 8'd18,
                                           8'd13, 8'd9, 8'd5, 8'd2};
   localparam logic [7:0][7:0] MOD_FAR  = {8'd183, 8'd106, 8'd80, 8'd60,
                                           8'd42, 8'd29, 8'd17, 8'd8};

   logic                      alpha_enabled;
   logic                      premultiply_enabled;
   etc1_pkg::rsp_payload_type expected_pixels[$];
   etc1_pkg::rsp_payload_type want;
   int                        pixel_beats;

   function automatic logic [7:0] base_value(input logic [31:0] ctl, input int hi,
                                             input logic second, input logic diff);
      logic [4:0] v5;
      logic [2:0] delta;
      logic [3:0] v4;
      if (diff) begin
         v5 = ctl[hi -: 5];
         if (second) begin
            delta = ctl[hi - 5 -: 3];
            v5 = v5 + {{2{delta[2]}}, delta};
         end
         return {v5, v5[4:2]};
      end
      v4 = second ? ctl[hi - 4 -: 4] : ctl[hi -: 4];
      return {v4, v4};
   endfunction

   function automatic int modified_channel(input logic [7:0] base, input logic [7:0] mag,
                                           input logic neg);
      int sum;
      sum = neg ? int'(base) - int'(mag) : int'(base) + int'(mag);
      if (sum < 0) return 0;
      if (sum > 255) return 255;
      return sum;
   endfunction

   task automatic predict_block_pixels(input logic [63:0] color_word,
                                       input logic [63:0] alpha_word);
      logic [31:0]               ctl;
      logic                      second;
      logic [2:0]                tbl;
      logic [7:0]                mag;
      logic                      neg;
      int                        px;
      int                        py;
      int                        r;
      int                        g;
      int                        b;
      int                        a;
      etc1_pkg::rsp_payload_type pix;
      ctl = color_word[63:32];
      for (int k = 0; k < 16; k++) begin
         px = k >> 2;
         py = k & 3;
         second = ((ctl[0] ? py : px) >= 2);
         tbl = second ? ctl[4:2] : ctl[7:5];
         mag = color_word[k] ? MOD_FAR[tbl] : MOD_NEAR[tbl];
         neg = color_word[16 + k];
         r = modified_channel(base_value(ctl, 31, second, ctl[1]), mag, neg);
         g = modified_channel(base_value(ctl, 23, second, ctl[1]), mag, neg);
         b = modified_channel(base_value(ctl, 15, second, ctl[1]), mag, neg);
         a = alpha_enabled ? int'(alpha_word[4 * k +: 4]) * 17 : 255;
         if (premultiply_enabled) begin
            r = (r * a) / 255;
            g = (g * a) / 255;
            b = (b * a) / 255;
         end
         pix.red = r[7:0];
         pix.green = g[7:0];
         pix.blue = b[7:0];
         pix.alpha = a[7:0];
         pix.pixel_x = px[1:0];
         pix.pixel_y = py[1:0];
         pix.last_pixel = (k == 15);
         expected_pixels.push_back(pix);
      end
   endtask

   task automatic report_mismatch(input string field, input int got_value,
                                  input int want_value);
      if (failures < PRINT_CAP)
         $display("pixel beat %0d: %s got %0d, expected %0d",
                  pixel_beats, field, got_value, want_value);
      failures++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         alpha_enabled = 1'b0;
         premultiply_enabled = 1'b0;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == etc1_pkg::CSR_HAS_ALPHA) alpha_enabled = csr_wdata;
            else if (csr_index == etc1_pkg::CSR_PREMULTIPLY) premultiply_enabled = csr_wdata;
         end
         if (req_valid && req_ready)
            predict_block_pixels(req_payload.color_word, req_payload.alpha_word);
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("beat with nothing expected", 1, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_payload.red !== want.red)
                  report_mismatch("red", int'(rsp_payload.red), int'(want.red));
               if (rsp_payload.green !== want.green)
                  report_mismatch("green", int'(rsp_payload.green), int'(want.green));
               if (rsp_payload.blue !== want.blue)
                  report_mismatch("blue", int'(rsp_payload.blue), int'(want.blue));
               if (rsp_payload.alpha !== want.alpha)
                  report_mismatch("alpha", int'(rsp_payload.alpha), int'(want.alpha));
               if (rsp_payload.pixel_x !== want.pixel_x)
                  report_mismatch("pixel_x", int'(rsp_payload.pixel_x),
                                  int'(want.pixel_x));
               if (rsp_payload.pixel_y !== want.pixel_y)
                  report_mismatch("pixel_y", int'(rsp_payload.pixel_y),
                                  int'(want.pixel_y));
               if (rsp_payload.last_pixel !== want.last_pixel)
                  report_mismatch("last_pixel", int'(rsp_payload.last_pixel),
                                  int'(want.last_pixel));
            end
            pixel_beats++;
         end
      end
      pending_pixels = expected_pixels.size();
   end

endmodule

// ----- tb/etc1_block_decoder_tb.sv -----
// Testbench top for the ETC1 block decoder: clock, reset, register writes and
// block stimulus with bursty sending and a stalling receiver, plus the verdict.
// Depends on etc1_pkg, etc1_stream_if, etc1_block_decoder and the checker.
`timescale 1ns / 1ps
module etc1_block_decoder_tb;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_PER_PHASE = 77;
   localparam int DIRECTED_BLOCKS = 12;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_AFTER = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic csr_wdata = 1'b0;
   int   failures;
   int   pending_pixels;
   int   cycle_count = 0;
   int   block_beats = 0;
   int   burst_left = 0;
   bit   long_hold_done = 1'b0;

   etc1_stream_if #(.payload_type(etc1_pkg::req_payload_type)) req_bus ();
   etc1_stream_if #(.payload_type(etc1_pkg::rsp_payload_type)) rsp_bus ();

   etc1_block_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   etc1_block_decoder_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_payload    (req_bus.payload),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_payload    (rsp_bus.payload),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .failures       (failures),
      .pending_pixels (pending_pixels)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("etc1_block_decoder_tb: errors");
         $finish;
      end
   end

   // Zero bases with the largest negative modifiers must clamp to 0, full bases
   // with the largest positive ones to 255; the differential blocks wrap both ways.
   function automatic logic [63:0] directed_color(input int i);
      case (i)
         0:       return 64'h00000000_00000000;
         1:       return 64'hFFFFFFFF_FFFFFFFF;
         2:       return 64'h000000FC_FFFFFFFF;
         3:       return 64'hFFFFFFFC_0000FFFF;
         4:       return 64'hFFFFFFFD_0000FFFF;
         5:       return 64'hFBFBFB02_00000000;
         6:       return 64'h04040402_FFFF0000;
         7:       return 64'h8A53C897_5A5AC33C;
         8:       return 64'h1E2D3C4D_0F0FF0F0;
         9:       return 64'h7799AA24_3C3CC3C3;
         10:      return 64'h665544DA_A5A55A5A;
         default: return 64'h55555555_AAAAAAAA;
      endcase
   endfunction

   function automatic logic [63:0] directed_alpha(input int i);
      case (i % 5)
         0:       return 64'h0;
         1:       return 64'hFFFFFFFF_FFFFFFFF;
         2:       return 64'h01234567_89ABCDEF;
         3:       return 64'hFEDCBA98_76543210;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic make_random_block(output logic [63:0] color_word,
                                    output logic [63:0] alpha_word);
      color_word = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0:       color_word[63:40] = '1;
         1:       color_word[63:40] = '0;
         2:       color_word[31:0] = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0000FFFF;
         default: ;
      endcase
      case ($urandom_range(0, 7))
         0:       alpha_word = '0;
         1:       alpha_word = '1;
         default: alpha_word = {$urandom, $urandom};
      endcase
   endtask

   task automatic write_register(input etc1_pkg::csr_index_type index, input logic value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_block(input logic [63:0] color_word, input logic [63:0] alpha_word);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.payload.color_word = color_word;
      req_bus.payload.alpha_word = alpha_word;
      do @(posedge clock); while (!req_bus.ready);
      block_beats++;
   endtask

   task automatic run_phase(input logic alpha_on, input logic premultiply_on,
                            input bit with_directed, input int random_blocks);
      logic [63:0] color_word;
      logic [63:0] alpha_word;
      write_register(etc1_pkg::CSR_HAS_ALPHA, alpha_on);
      write_register(etc1_pkg::CSR_PREMULTIPLY, premultiply_on);
      if (with_directed)
         for (int i = 0; i < DIRECTED_BLOCKS; i++)
            send_block(directed_color(i), directed_alpha(i));
      for (int i = 0; i < random_blocks; i++) begin
         make_random_block(color_word, alpha_word);
         send_block(color_word, alpha_word);
      end
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_pixels != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   initial begin : receiver
      int mode;
      int seg_len;
      rsp_bus.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         seg_len = $urandom_range(4, 40);
         repeat (seg_len) begin
            @(negedge clock);
            if (!long_hold_done && block_beats >= LONG_HOLD_AFTER) begin
               long_hold_done = 1'b1;
               rsp_bus.ready = 1'b0;
               repeat (LONG_HOLD_CYCLES) @(negedge clock);
            end
            case (mode)
               0, 1:    rsp_bus.ready = 1'b1;
               2:       rsp_bus.ready = $urandom_range(0, 1);
               default: rsp_bus.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;
      run_phase(1'b0, 1'b0, 1'b1, 0);
      run_phase(1'b1, 1'b1, 1'b1, 0);
      run_phase(1'b1, 1'b0, 1'b0, RANDOM_PER_PHASE);
      run_phase(1'b0, 1'b1, 1'b0, RANDOM_PER_PHASE);
      run_phase(1'b1, 1'b1, 1'b0, RANDOM_PER_PHASE);
      run_phase(1'b0, 1'b0, 1'b0, RANDOM_PER_PHASE);
      if (failures == 0) begin
         $display("etc1_block_decoder_tb: clean");
      end else begin
         $display("etc1_block_decoder_tb: errors");
      end
      $finish;
   end

endmodule

// ----- etc1_block_decoder.f -----
hdl/etc1_pkg.sv
hdl/etc1_stream_if.sv
hdl/etc1_front.sv
hdl/etc1_queue.sv
hdl/etc1_back.sv
hdl/etc1_block_decoder.sv
hdl/etc1_checker.sv
tb/etc1_block_decoder_checker.sv
tb/etc1_block_decoder_tb.sv
